### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam logic [7:0] IDLE_PRIO_RST = 8'd100;

	typedef enum logic [2:0] {
		REQ_CREATE_TASK  = 3'd0,
		REQ_DELAY        = 3'd1,
		REQ_TICK         = 3'd2,
		REQ_PEND         = 3'd3,
		REQ_SET          = 3'd4,
		REQ_CLEAR        = 3'd5,
		REQ_CREATE_GROUP = 3'd6,
		REQ_NONE         = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		TS_READY   = 2'd0,
		TS_DELAYED = 2'd1,
		TS_WAITING = 2'd2,
		TS_SPARE   = 2'd3
	} task_stat_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_EMPTY     = 2'd1,
		ERR_FULL      = 2'd2,
		ERR_BAD_GROUP = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

endpackage

### rtl/pts_pick_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pick_unit
// One step of the running-task search: keeps the ready slot with the
// smallest priority number, lowest slot winning ties.
// ----------------------------------------------------------------------------
module pts_pick_unit #(
	parameter int SW = 3
) (
	input  logic          cand_ok,
	input  logic [7:0]    cand_prio,
	input  logic [SW-1:0] cand_idx,
	input  logic          found_in,
	input  logic [7:0]    prio_in,
	input  logic [SW-1:0] idx_in,
	output logic          found_out,
	output logic [7:0]    prio_out,
	output logic [SW-1:0] idx_out
);
	logic take;

	assign take      = cand_ok && (!found_in || (cand_prio < prio_in));
	assign found_out = found_in || cand_ok;
	assign prio_out  = take ? cand_prio : prio_in;
	assign idx_out   = take ? cand_idx : idx_in;
endmodule

### rtl/priority_task_scheduler_event_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_event_flags
// Hardware kernel scheduler: task table, event flag groups, running-task pick.
// ----------------------------------------------------------------------------
// A request (req_type and its operands) is taken at a clock edge with start
// high and busy low. busy then stays high while the block works: the EXEC state
// applies the request, then the SCAN state walks the table slot by slot, aging
// delayed tasks on a tick, releasing waiters on a set, and feeding the shared
// priority comparator that picks the running task.
// The result is shown for exactly one cycle with done high; running_task,
// task_switched, group_flags, error_code and tick_count hold until the next
// result. The receiver cannot stall, so busy drops in the cycle done rises
// and the next request can be taken there.
// The idle_priority register is written through cfg_valid/cfg_data; cfg_ready
// is always high. Writes are expected only while no request is in flight.
// After reset the idle task sits ready in slot 0 at priority 100, no group
// exists and the tick count is zero.
// ----------------------------------------------------------------------------
module priority_task_scheduler_event_flags #(
	parameter int TASK_SLOTS   = 8,
	parameter int EVENT_GROUPS = 4,
	parameter int FLAG_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  task_priority,
	input  logic [15:0] delay_ticks,
	input  logic [1:0]  event_group,
	input  logic [15:0] flag_mask,
	input  logic        wait_all_mode,
	output logic        done,
	output logic [2:0]  running_task,
	output logic        task_switched,
	output logic [15:0] group_flags,
	output logic [1:0]  error_code,
	output logic [15:0] tick_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import pts_pkg::*;

	localparam int SW  = $clog2(TASK_SLOTS);
	localparam int TCW = $clog2(TASK_SLOTS + 1);
	localparam int GW  = (EVENT_GROUPS > 1) ? $clog2(EVENT_GROUPS) : 1;
	localparam int GCW = $clog2(EVENT_GROUPS + 1);

	function automatic logic cond_holds(input logic [FLAG_BITS-1:0] w,
		input logic [FLAG_BITS-1:0] m, input logic all);
		if (all)
			return (w & m) == m;
		return (w & m) != '0;
	endfunction

	state_t state_q, state_d;

	logic                 used_q  [TASK_SLOTS];
	logic [7:0]           prio_q  [TASK_SLOTS];
	task_stat_t           stat_q  [TASK_SLOTS];
	logic [15:0]          delay_q [TASK_SLOTS];
	logic [FLAG_BITS-1:0] wmask_q [TASK_SLOTS];
	logic                 wall_q  [TASK_SLOTS];
	logic [1:0]           wgrp_q  [TASK_SLOTS];
	logic [FLAG_BITS-1:0] gword_q [EVENT_GROUPS];
	logic [GCW-1:0]       groups_q;
	logic [TCW-1:0]       tasks_q;
	logic [SW-1:0]        cur_q;
	logic [15:0]          ticks_q;

	req_t                 req_q;
	logic [7:0]           tprio_q;
	logic [15:0]          dly_q;
	logic [1:0]           grp_q;
	logic [FLAG_BITS-1:0] mask_q;
	logic                 all_q;
	logic                 tick_q, set_q;
	logic [FLAG_BITS-1:0] flags_q;
	err_t                 err_q;

	logic [SW-1:0]        idx_q;
	logic                 found_q;
	logic [7:0]           bprio_q;
	logic [SW-1:0]        bidx_q;

	logic [TASK_SLOTS-1:0] rdy_vec;
	logic                  accept, grp_ok, last, cand_ok;
	logic [GW-1:0]         gidx;
	task_stat_t            ns;
	logic [15:0]           nd;
	logic                  pk_found;
	logic [7:0]            pk_prio;
	logic [SW-1:0]         pk_idx;
	logic [FLAG_BITS-1:0]  set_word;
	logic [SW-1:0]         new_slot;

	genvar gi;
	generate
		for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_rdy
			assign rdy_vec[gi] = used_q[gi] && (stat_q[gi] == TS_READY);
		end
	endgenerate

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign gidx      = GW'(grp_q);
	assign grp_ok    = 32'(grp_q) < 32'(groups_q);
	assign last      = (idx_q == SW'(TASK_SLOTS - 1));
	assign set_word  = gword_q[gidx] | mask_q;
	assign new_slot  = SW'(tasks_q);

	// per-slot update on the walk
	always_comb begin
		ns = stat_q[idx_q];
		nd = delay_q[idx_q];
		if (tick_q && used_q[idx_q] && (stat_q[idx_q] == TS_DELAYED)) begin
			if (delay_q[idx_q] <= 16'd1) begin
				nd = 16'd0;
				ns = TS_READY;
			end else begin
				nd = delay_q[idx_q] - 16'd1;
			end
		end
		if (set_q && used_q[idx_q] && (stat_q[idx_q] == TS_WAITING) &&
			(wgrp_q[idx_q] == grp_q) &&
			cond_holds(gword_q[gidx], wmask_q[idx_q], wall_q[idx_q]))
			ns = TS_READY;
		cand_ok = used_q[idx_q] && (ns == TS_READY);
	end

	pts_pick_unit #(.SW(SW)) u_pick (
		.cand_ok   (cand_ok),
		.cand_prio (prio_q[idx_q]),
		.cand_idx  (idx_q),
		.found_in  (found_q),
		.prio_in   (bprio_q),
		.idx_in    (bidx_q),
		.found_out (pk_found),
		.prio_out  (pk_prio),
		.idx_out   (pk_idx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_SCAN;
			ST_SCAN: begin
				if (last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(req_type);
			tprio_q <= task_priority;
			dly_q   <= delay_ticks;
			grp_q   <= event_group;
			mask_q  <= FLAG_BITS'(flag_mask);
			all_q   <= wait_all_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				used_q[i]  <= (i == 0);
				prio_q[i]  <= (i == 0) ? IDLE_PRIO_RST : 8'd0;
				stat_q[i]  <= TS_READY;
				delay_q[i] <= 16'd0;
				wmask_q[i] <= '0;
				wall_q[i]  <= 1'b0;
				wgrp_q[i]  <= 2'd0;
			end
			for (int g = 0; g < EVENT_GROUPS; g++)
				gword_q[g] <= '0;
			groups_q <= '0;
			tasks_q  <= TCW'(1);
			cur_q    <= '0;
			ticks_q  <= 16'd0;
			tick_q   <= 1'b0;
			set_q    <= 1'b0;
			flags_q  <= '0;
			err_q    <= ERR_OK;
			idx_q    <= '0;
			found_q  <= 1'b0;
			bprio_q  <= 8'd0;
			bidx_q   <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (state_q == ST_EXEC) begin
				tick_q  <= 1'b0;
				set_q   <= 1'b0;
				flags_q <= '0;
				err_q   <= ERR_OK;
				idx_q   <= '0;
				found_q <= 1'b0;
				unique case (req_q)
					REQ_CREATE_TASK: begin
						if (32'(tasks_q) >= TASK_SLOTS) begin
							err_q <= ERR_FULL;
						end else begin
							used_q[new_slot]  <= 1'b1;
							prio_q[new_slot]  <= tprio_q;
							stat_q[new_slot]  <= TS_READY;
							delay_q[new_slot] <= 16'd0;
							tasks_q <= tasks_q + TCW'(1);
						end
					end
					REQ_DELAY: begin
						if ((dly_q != 16'd0) && rdy_vec[cur_q]) begin
							stat_q[cur_q]  <= TS_DELAYED;
							delay_q[cur_q] <= dly_q;
						end
					end
					REQ_TICK: begin
						ticks_q <= ticks_q + 16'd1;
						tick_q  <= 1'b1;
					end
					REQ_PEND: begin
						if (!grp_ok) begin
							err_q <= ERR_BAD_GROUP;
						end else begin
							flags_q <= gword_q[gidx];
							if (mask_q == '0)
								err_q <= ERR_EMPTY;
							else if (rdy_vec[cur_q] &&
								!cond_holds(gword_q[gidx], mask_q, all_q)) begin
								stat_q[cur_q]  <= TS_WAITING;
								wmask_q[cur_q] <= mask_q;
								wall_q[cur_q]  <= all_q;
								wgrp_q[cur_q]  <= grp_q;
							end
						end
					end
					REQ_SET: begin
						if (!grp_ok) begin
							err_q <= ERR_BAD_GROUP;
						end else if (mask_q == '0) begin
							err_q   <= ERR_EMPTY;
							flags_q <= gword_q[gidx];
						end else begin
							gword_q[gidx] <= set_word;
							flags_q <= set_word;
							set_q   <= 1'b1;
						end
					end
					REQ_CLEAR: begin
						if (!grp_ok) begin
							err_q <= ERR_BAD_GROUP;
						end else begin
							gword_q[gidx] <= gword_q[gidx] & ~mask_q;
							flags_q <= gword_q[gidx] & ~mask_q;
						end
					end
					REQ_CREATE_GROUP: begin
						if (32'(groups_q) >= EVENT_GROUPS) begin
							err_q <= ERR_FULL;
						end else begin
							gword_q[GW'(groups_q)] <= mask_q;
							flags_q  <= mask_q;
							groups_q <= groups_q + GCW'(1);
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_SCAN) begin
				stat_q[idx_q]  <= ns;
				delay_q[idx_q] <= nd;
				found_q <= pk_found;
				bprio_q <= pk_prio;
				bidx_q  <= pk_idx;
				idx_q   <= idx_q + SW'(1);
				if (last) begin
					done <= 1'b1;
					if (pk_found)
						cur_q <= pk_idx;
				end
			end
			if (cfg_valid)
				prio_q[0] <= cfg_data;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && last) begin
			running_task  <= 3'(pk_found ? pk_idx : cur_q);
			task_switched <= pk_found && (pk_idx != cur_q);
			group_flags   <= 16'(flags_q);
			error_code    <= err_q;
			tick_count    <= ticks_q;
		end
	end
endmodule

### rtl/pts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks on the scheduler's request and result timing.
// ----------------------------------------------------------------------------
module pts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy))
		else $error("result without a request in flight");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");
endmodule

bind priority_task_scheduler_event_flags pts_checker u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority task scheduler with event flags. A
// queue of requests feeds a clocked driver; a clocked monitor checks each
// result against a scheduler model kept in step with every accepted request.
// ----------------------------------------------------------------------------
module tb;
	import pts_pkg::*;

	localparam int SLOTS = 8;
	localparam int GROUPS = 4;
	localparam int WDOG_LIMIT = 5000;

	typedef struct packed {
		req_t        kind;
		logic [7:0]  prio;
		logic [15:0] ticks;
		logic [1:0]  grp;
		logic [15:0] mask;
		logic        all;
	} sched_req_t;

	typedef struct packed {
		logic [2:0]  running;
		logic        switched;
		logic [15:0] flags;
		err_t        err;
		logic [15:0] tick_cnt;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] req_type = '0;
	logic [7:0] task_priority = '0;
	logic [15:0] delay_ticks = '0;
	logic [1:0] event_group = '0;
	logic [15:0] flag_mask = '0;
	logic wait_all_mode = 1'b0;
	logic done;
	logic [2:0] running_task;
	logic task_switched;
	logic [15:0] group_flags;
	logic [1:0] error_code;
	logic [15:0] tick_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	priority_task_scheduler_event_flags i_dut (
		.clk, .arst_n, .start, .busy, .req_type, .task_priority, .delay_ticks,
		.event_group, .flag_mask, .wait_all_mode, .done, .running_task,
		.task_switched, .group_flags, .error_code, .tick_count,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	always #6 clk = ~clk;

	// scheduler model state
	logic             m_used [SLOTS];
	logic [7:0]       m_prio [SLOTS];
	task_stat_t       m_stat [SLOTS];
	logic [15:0]      m_delay [SLOTS];
	logic [15:0]      m_wmask [SLOTS];
	logic             m_wall [SLOTS];
	logic [1:0]       m_wgrp [SLOTS];
	logic [15:0]      m_word [GROUPS];
	int               m_groups, m_tasks;
	logic [2:0]       m_cur;
	logic [15:0]      m_ticks;

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int n_errors = 0, n_checked = 0, n_sent = 0;
	int wdog = 0;
	bit drive_en = 1'b0;
	bit no_idle = 1'b0;
	int n_switches = 0, n_errcodes = 0;

	function automatic bit cond_met(logic [15:0] w, logic [15:0] m, logic a);
		return a ? ((w & m) == m) : ((w & m) != 0);
	endfunction

	function automatic bit cur_ready();
		return m_used[m_cur] && m_stat[m_cur] == TS_READY;
	endfunction

	task automatic sched_reset();
		for (int i = 0; i < SLOTS; i++) begin
			m_used[i] = 0; m_prio[i] = 0; m_stat[i] = TS_READY; m_delay[i] = 0;
			m_wmask[i] = 0; m_wall[i] = 0; m_wgrp[i] = 0;
		end
		for (int g = 0; g < GROUPS; g++) m_word[g] = 0;
		m_used[0] = 1; m_prio[0] = IDLE_PRIO_RST;
		m_groups = 0; m_tasks = 1; m_cur = 0; m_ticks = 0;
	endtask

	function automatic sched_res_t schedule(sched_req_t r);
		sched_res_t res;
		logic [2:0] prev;
		logic [15:0] fl;
		err_t e;
		bit gok;
		bit found;
		int best;
		prev = m_cur; fl = 0; e = ERR_OK;
		gok = r.grp < m_groups;
		case (r.kind)
			REQ_CREATE_TASK: begin
				if (m_tasks >= SLOTS) e = ERR_FULL;
				else begin
					m_used[m_tasks] = 1; m_prio[m_tasks] = r.prio;
					m_stat[m_tasks] = TS_READY; m_delay[m_tasks] = 0;
					m_tasks++;
				end
			end
			REQ_DELAY: begin
				if (r.ticks != 0 && cur_ready()) begin
					m_stat[m_cur] = TS_DELAYED; m_delay[m_cur] = r.ticks;
				end
			end
			REQ_TICK: begin
				m_ticks++;
				for (int i = 0; i < SLOTS; i++)
					if (m_used[i] && m_stat[i] == TS_DELAYED) begin
						if (m_delay[i] <= 1) begin
							m_delay[i] = 0; m_stat[i] = TS_READY;
						end else m_delay[i]--;
					end
			end
			REQ_PEND: begin
				if (!gok) e = ERR_BAD_GROUP;
				else if (r.mask == 0) begin
					e = ERR_EMPTY; fl = m_word[r.grp];
				end else begin
					if (cur_ready() && !cond_met(m_word[r.grp], r.mask, r.all)) begin
						m_stat[m_cur] = TS_WAITING; m_wmask[m_cur] = r.mask;
						m_wall[m_cur] = r.all; m_wgrp[m_cur] = r.grp;
					end
					fl = m_word[r.grp];
				end
			end
			REQ_SET: begin
				if (!gok) e = ERR_BAD_GROUP;
				else if (r.mask == 0) begin
					e = ERR_EMPTY; fl = m_word[r.grp];
				end else begin
					m_word[r.grp] |= r.mask;
					for (int i = 0; i < SLOTS; i++)
						if (m_used[i] && m_stat[i] == TS_WAITING && m_wgrp[i] == r.grp &&
							cond_met(m_word[r.grp], m_wmask[i], m_wall[i]))
							m_stat[i] = TS_READY;
					fl = m_word[r.grp];
				end
			end
			REQ_CLEAR: begin
				if (!gok) e = ERR_BAD_GROUP;
				else begin
					m_word[r.grp] &= ~r.mask; fl = m_word[r.grp];
				end
			end
			REQ_CREATE_GROUP: begin
				if (m_groups >= GROUPS) e = ERR_FULL;
				else begin
					m_word[m_groups] = r.mask; fl = r.mask; m_groups++;
				end
			end
			default: ;
		endcase
		found = 0; best = 0;
		for (int i = 0; i < SLOTS; i++)
			if (m_used[i] && m_stat[i] == TS_READY)
				if (!found || m_prio[i] < m_prio[best]) begin
					best = i; found = 1;
				end
		if (found) m_cur = best[2:0];
		res.running = m_cur;
		res.switched = (m_cur != prev);
		res.flags = fl;
		res.err = e;
		res.tick_cnt = m_ticks;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		n_errors++;
		$display("mismatch %0d: %s got 0x%0h expected 0x%0h", n_checked, what, got, want);
	endtask

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_results.push_back(schedule({req_t'(req_type), task_priority,
				delay_ticks, event_group, flag_mask, wait_all_mode}));
			n_sent++;
		end
		if (!(start && busy)) begin
			if (drive_en && pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 25))
			begin
				sched_req_t r;
				r = pending_reqs.pop_front();
				start <= 1'b1;
				req_type <= r.kind; task_priority <= r.prio; delay_ticks <= r.ticks;
				event_group <= r.grp; flag_mask <= r.mask; wait_all_mode <= r.all;
			end else start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				n_errors++;
				$display("unexpected result");
			end else begin
				sched_res_t x;
				x = expected_results.pop_front();
				if (running_task !== x.running)
					report_mismatch("running_task", running_task, x.running);
				if (task_switched !== x.switched)
					report_mismatch("task_switched", task_switched, x.switched);
				if (group_flags !== x.flags)
					report_mismatch("group_flags", group_flags, x.flags);
				if (error_code !== x.err)
					report_mismatch("error_code", error_code, x.err);
				if (tick_count !== x.tick_cnt)
					report_mismatch("tick_count", tick_count, x.tick_cnt);
				if (x.switched) n_switches++;
				if (x.err != ERR_OK) n_errcodes++;
			end
			n_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_valid) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("timeout");
			$display("FAILURE");
			$finish;
		end
	end

	function automatic sched_req_t mk(req_t k, logic [7:0] p, logic [15:0] t,
		logic [1:0] g, logic [15:0] m, logic a);
		sched_req_t r;
		r.kind = k; r.prio = p; r.ticks = t; r.grp = g; r.mask = m; r.all = a;
		return r;
	endfunction

	function automatic sched_req_t rand_req(bit noisy);
		sched_req_t r;
		int pick;
		r.prio = $urandom; r.grp = $urandom; r.all = $urandom;
		r.ticks = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
		r.mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(15))
			| 16'(1 << $urandom_range(15));
		if ($urandom_range(19) == 0) r.mask = 0;
		pick = $urandom_range(99);
		if (noisy) r.kind = req_t'($urandom_range(7));
		else if (pick < 12) r.kind = REQ_CREATE_TASK;
		else if (pick < 27) r.kind = REQ_DELAY;
		else if (pick < 50) r.kind = REQ_TICK;
		else if (pick < 65) r.kind = REQ_PEND;
		else if (pick < 82) r.kind = REQ_SET;
		else if (pick < 92) r.kind = REQ_CLEAR;
		else if (pick < 97) r.kind = REQ_CREATE_GROUP;
		else r.kind = REQ_NONE;
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_results.size() > 0 || start)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_idle_prio(logic [7:0] v);
		cfg_valid <= 1'b1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		m_prio[0] = v;
	endtask

	initial begin
		logic [7:0] idle_vals [4];
		idle_vals = '{8'd0, 8'd255, 8'd100, 8'd37};
		sched_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_en = 1'b1;
		// directed: bad groups, empty masks, group fill, task fill, waits and delays
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 0, 16'h1, 0));
		pending_reqs.push_back(mk(REQ_SET, 0, 0, 3, 16'hFFFF, 0));
		pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 2, 16'h0, 0));
		pending_reqs.push_back(mk(REQ_CREATE_GROUP, 0, 0, 0, 16'h0000, 0));
		pending_reqs.push_back(mk(REQ_CREATE_GROUP, 0, 0, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk(REQ_CREATE_GROUP, 0, 0, 0, 16'h8001, 0));
		pending_reqs.push_back(mk(REQ_CREATE_GROUP, 0, 0, 0, 16'h00F0, 1));
		pending_reqs.push_back(mk(REQ_CREATE_GROUP, 0, 0, 0, 16'h1234, 0));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 1, 16'h0, 0));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 1, 16'h00FF, 0));
		pending_reqs.push_back(mk(REQ_CREATE_TASK, 8'd0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 0, 16'h0003, 1));
		pending_reqs.push_back(mk(REQ_SET, 0, 0, 0, 16'h0000, 0));
		pending_reqs.push_back(mk(REQ_SET, 0, 0, 0, 16'h0001, 0));
		pending_reqs.push_back(mk(REQ_SET, 0, 0, 0, 16'h0002, 0));
		pending_reqs.push_back(mk(REQ_CREATE_TASK, 8'd255, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELAY, 0, 16'd0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELAY, 0, 16'd2, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELAY, 0, 16'hFFFF, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_CLEAR, 0, 0, 3, 16'hFFFF, 0));
		pending_reqs.push_back(mk(REQ_NONE, 8'hFF, 16'hFFFF, 3, 16'hFFFF, 1));
		for (int i = 0; i < 7; i++) pending_reqs.push_back(mk(REQ_CREATE_TASK, 8'd7, 0, 0, 0, 0));
		wait_drained();
		// random phases, each under a different idle priority; the fill state
		// persists, so early phases use normal mix and the last adds noise
		for (int ph = 0; ph < 4; ph++) begin
			write_idle_prio(idle_vals[ph]);
			no_idle = (ph == 2);
			for (int k = 0; k < 450; k++) pending_reqs.push_back(rand_req(ph == 3));
			wait_drained();
		end
		$display("run covered %0d requests, %0d checked, %0d task switches, %0d error results",
			n_sent, n_checked, n_switches, n_errcodes);
		if (n_errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
rtl/pts_pkg.sv
rtl/pts_pick_unit.sv
rtl/priority_task_scheduler_event_flags.sv
rtl/pts_checker.sv
sim/tb.sv
